FILE: rtl/pnc_pkg.sv
// Package for the paste normalizer and chunker: sizes, payload and config types,
// character codes, and the marker byte table.
// Depends on nothing; every other file in rtl/ uses it by scoped names.
package pnc_pkg;

  // Largest chunk in bytes; the store holds one chunk plus the byte after it.
  localparam int CHUNK_MAX   = 16;
  localparam int STORE_DEPTH = CHUNK_MAX + 1;
  localparam int RING_AW     = $clog2(STORE_DEPTH);
  localparam int RING_DEPTH  = 2 ** RING_AW;
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

  // Fixed field widths.
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 24;
  localparam int CHUNK_SIZE_W = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRACKETED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 2'd3;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL        = 8'h7F;
  localparam logic [BYTE_W-1:0] UTF_CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] UTF_CONT_TAG  = 8'h80;

  // Bracket markers are six bytes long.
  localparam int MARK_W = 3;
  localparam logic [MARK_W-1:0] MARK_LAST = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              first_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  total_length;
  } pnc_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              chunk_end;
    logic              rejected;
    logic              run_last;
  } pnc_out_t;

  typedef struct packed {
    logic                    bracketed_mode;
    logic                    strip_controls;
    logic [LEN_W-1:0]        max_length;
    logic [CHUNK_SIZE_W-1:0] chunk_size;
  } pnc_cfg_t;

  // One write port and one read port of the chunk store.
  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } pnc_mem_req_t;

  // True for a UTF-8 continuation byte (10xxxxxx).
  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return (b & UTF_CONT_MASK) == UTF_CONT_TAG;
  endfunction

  // Byte idx of the start marker ESC[200~ or the end marker ESC[201~.
  function automatic logic [BYTE_W-1:0] mark_byte(input logic is_end,
                                                  input logic [MARK_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      3'd0:    b = 8'h1B;
      3'd1:    b = 8'h5B;
      3'd2:    b = 8'h32;
      3'd3:    b = 8'h30;
      3'd4:    b = is_end ? 8'h31 : 8'h30;
      3'd5:    b = 8'h7E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/paste_normalize_chunker.sv
// Top level of the paste normalizer and chunker: config registers, sequencer and
// chunk store. Depends on pnc_pkg, pnc_cfg, pnc_ctrl and pnc_store.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o   | pnc_in_t: one raw paste byte
//   out     | output    | out_valid_o/out_stall_i | pnc_out_t: one result byte
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte is in work at a time. A byte that is stored without a cut passes the
// write and check states, a control byte that is dropped or an LF merged into its
// CR only the check state, and a byte of a rejected paste none; the reject result
// itself passes the reject state. Each chunk byte sent passes a store read, then
// the output register, each marker byte its marker state, and each cut or flush a
// check state. The single read port of the chunk store sets the burst rate.
// Reset is asynchronous and active low; the store needs no clearing pass.
// A stall on the output holds the sequencer; the input is stalled while busy.
module paste_normalize_chunker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pnc_pkg::pnc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pnc_pkg::pnc_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pnc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pnc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  pnc_pkg::pnc_cfg_t          cfg;
  pnc_pkg::pnc_mem_req_t      mem_req;
  logic [pnc_pkg::BYTE_W-1:0] mem_rdata;

  // Configuration registers.
  pnc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Normalizing and chunking sequencer.
  pnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Chunk store.
  pnc_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: rtl/pnc_cfg.sv
// Configuration registers of the paste normalizer and chunker.
// Depends on pnc_pkg for the register indexes and the config struct.
module pnc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pnc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pnc_pkg::pnc_cfg_t              cfg_o
);

  pnc_pkg::pnc_cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register decode; each register keeps only its own low bits.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pnc_pkg::CFG_BRACKETED:  cfg_d.bracketed_mode = cfg_data_i[0];
        pnc_pkg::CFG_STRIP:      cfg_d.strip_controls = cfg_data_i[0];
        pnc_pkg::CFG_MAX_LENGTH: cfg_d.max_length = cfg_data_i[pnc_pkg::LEN_W-1:0];
        pnc_pkg::CFG_CHUNK_SIZE: cfg_d.chunk_size = cfg_data_i[pnc_pkg::CHUNK_SIZE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bracketed_mode <= 1'b1;
      cfg_q.strip_controls <= 1'b1;
      cfg_q.max_length     <= '1;
      cfg_q.chunk_size     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/pnc_store.sv
// Chunk store: a ring of bytes with one write port and one registered read port.
// Depends on pnc_pkg for the ring size and the request struct.
module pnc_store (
  input  logic                       clk_i,
  input  pnc_pkg::pnc_mem_req_t      req_i,
  output logic [pnc_pkg::BYTE_W-1:0] rdata_o
);

  logic [pnc_pkg::BYTE_W-1:0] mem_q [pnc_pkg::RING_DEPTH];
  logic [pnc_pkg::BYTE_W-1:0] rdata_q;

  // Write port, and a read register that holds its data until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pnc_ctrl.sv
// Sequencer of the paste normalizer: normalizes each byte, keeps the paste state,
// writes the chunk store and walks it to send chunks, markers and rejects.
// Depends on pnc_pkg; drives the pnc_store request port.
module pnc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pnc_pkg::pnc_cfg_t          cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pnc_pkg::pnc_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pnc_pkg::pnc_out_t          out_data_o,
  output pnc_pkg::pnc_mem_req_t      mem_req_o,
  input  logic [pnc_pkg::BYTE_W-1:0] mem_rdata_i
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_REJ   = 8'b0000_0010,
    S_START = 8'b0000_0100,
    S_WRITE = 8'b0000_1000,
    S_CHECK = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_DATA  = 8'b0100_0000,
    S_ENDM  = 8'b1000_0000
  } pnc_state_e;

  localparam int FW = pnc_pkg::FILL_W;
  localparam int AW = pnc_pkg::RING_AW;
  localparam int DEPTH = pnc_pkg::STORE_DEPTH;

  pnc_state_e state_q, state_d;

  // Paste state.
  logic [FW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     head_q, head_d;
  logic [DEPTH-1:0]  cont_q, cont_d;
  logic              pending_cr_q, pending_cr_d;
  logic              dropping_q, dropping_d;
  logic              sent_q, sent_d;

  // Current item and burst counters.
  logic [pnc_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                       have_q, have_d;
  logic                       last_q, last_d;
  logic [FW-1:0]              cnt_q, cnt_d;
  logic [FW-1:0]              len_q, len_d;
  logic [pnc_pkg::MARK_W-1:0] mcnt_q, mcnt_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  pnc_pkg::pnc_out_t out_q, out_d;
  logic              push, push_ok, clear_paste;

  logic [FW-1:0]              clen, cut_len, new_fill;
  logic [pnc_pkg::BYTE_W-1:0] c, nbyte;
  logic                       in_acc, too_big, drop_eff, after_cr, sent_eff, have_n;
  logic                       need_start, more_st, more_dt, chunk_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign push_ok    = !out_valid_q || !out_stall_i;

  // Effective chunk length: zero or too large selects the maximum.
  always_comb begin
    if (cfg_i.chunk_size == '0 ||
        cfg_i.chunk_size > pnc_pkg::CHUNK_SIZE_W'(pnc_pkg::CHUNK_MAX)) begin
      clen = FW'(pnc_pkg::CHUNK_MAX);
    end else begin
      clen = FW'(cfg_i.chunk_size);
    end
  end

  // Cut point: the highest lead byte position within one chunk length, else one.
  always_comb begin
    cut_len = FW'(1);
    for (int l = 1; l <= pnc_pkg::CHUNK_MAX; l++) begin
      if (FW'(l) <= clen && !cont_q[l]) begin
        cut_len = FW'(l);
      end
    end
  end

  // Normalization of the incoming byte against the paste state.
  always_comb begin
    c        = in_data_i.in_byte;
    too_big  = in_data_i.total_length > cfg_i.max_length;
    drop_eff = in_data_i.first_byte ? too_big : dropping_q;
    after_cr = in_data_i.first_byte ? 1'b0 : pending_cr_q;
    sent_eff = in_data_i.first_byte ? 1'b0 : sent_q;
    nbyte    = (c == pnc_pkg::CH_LF) ? pnc_pkg::CH_CR : c;
    if (c == pnc_pkg::CH_CR || c == pnc_pkg::CH_TAB) begin
      have_n = 1'b1;
    end else if (c == pnc_pkg::CH_LF) begin
      have_n = !after_cr;
    end else if (c < pnc_pkg::CH_SPACE || c == pnc_pkg::CH_DEL) begin
      have_n = cfg_i.bracketed_mode || !cfg_i.strip_controls;
    end else begin
      have_n = 1'b1;
    end
    need_start = !drop_eff && have_n && cfg_i.bracketed_mode && !sent_eff;
  end

  // Look-ahead for the run_last flag.
  assign new_fill   = fill_q - len_q;
  assign more_st    = last_q || (fill_q >= clen);
  assign more_dt    = (have_q && new_fill > clen) || (last_q && (new_fill != '0 || sent_q));
  assign chunk_last = (cnt_q == len_q - FW'(1));

  // Main sequencer.
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    head_d       = head_q;
    cont_d       = cont_q;
    pending_cr_d = pending_cr_q;
    dropping_d   = dropping_q;
    sent_d       = sent_q;
    byte_d       = byte_q;
    have_d       = have_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    mcnt_d       = mcnt_q;
    out_d        = out_q;
    push         = 1'b0;
    clear_paste  = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = head_q + fill_q[AW-1:0];
    mem_req_o.wdata = byte_q;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = head_q + cnt_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          byte_d = nbyte;
          last_d = in_data_i.last_byte;
          have_d = !drop_eff && have_n;
          mcnt_d = '0;
          if (in_data_i.first_byte) begin
            fill_d       = '0;
            sent_d       = 1'b0;
            pending_cr_d = 1'b0;
            dropping_d   = too_big;
          end
          if (!drop_eff) begin
            pending_cr_d = (c == pnc_pkg::CH_CR);
          end
          priority if (in_data_i.first_byte && too_big) begin
            state_d = S_REJ;
          end else if (drop_eff) begin
            clear_paste = in_data_i.last_byte;
          end else if (need_start) begin
            sent_d  = 1'b1;
            state_d = S_START;
          end else if (have_n) begin
            state_d = S_WRITE;
          end else begin
            state_d = S_CHECK;
          end
        end
      end

      // Single reject result; the rest of the paste is dropped.
      S_REJ: begin
        if (push_ok) begin
          push        = 1'b1;
          out_d       = '{out_byte: '0, chunk_end: 1'b0, rejected: 1'b1, run_last: 1'b1};
          clear_paste = last_q;
          state_d     = S_IDLE;
        end
      end

      S_START: begin
        if (push_ok) begin
          push  = 1'b1;
          out_d = '{out_byte: pnc_pkg::mark_byte(1'b0, mcnt_q),
                    chunk_end: (mcnt_q == pnc_pkg::MARK_LAST),
                    rejected: 1'b0,
                    run_last: (mcnt_q == pnc_pkg::MARK_LAST) && !more_st};
          if (mcnt_q == pnc_pkg::MARK_LAST) begin
            state_d = S_WRITE;
          end else begin
            mcnt_d = mcnt_q + pnc_pkg::MARK_W'(1);
          end
        end
      end

      // Append the byte at the tail of the ring.
      S_WRITE: begin
        mem_req_o.we             = 1'b1;
        cont_d[fill_q[AW-1:0]]   = pnc_pkg::is_cont(byte_q);
        fill_d                   = fill_q + FW'(1);
        state_d                  = S_CHECK;
      end

      // Choose the next burst: a cut, the final flush, the end marker, or done.
      S_CHECK: begin
        cnt_d  = '0;
        mcnt_d = '0;
        priority if (have_q && fill_q > clen) begin
          len_d   = cut_len;
          state_d = S_RD;
        end else if (last_q && fill_q != '0) begin
          len_d   = fill_q;
          state_d = S_RD;
        end else if (last_q && sent_q) begin
          state_d = S_ENDM;
        end else begin
          clear_paste = last_q;
          state_d     = S_IDLE;
        end
      end

      S_RD: begin
        mem_req_o.re = 1'b1;
        state_d      = S_DATA;
      end

      // Present one stored byte; at the end of the chunk drop it from the ring.
      S_DATA: begin
        if (push_ok) begin
          push  = 1'b1;
          out_d = '{out_byte: mem_rdata_i, chunk_end: chunk_last, rejected: 1'b0,
                    run_last: chunk_last && !more_dt};
          if (chunk_last) begin
            head_d  = head_q + len_q[AW-1:0];
            fill_d  = new_fill;
            cont_d  = cont_q >> len_q;
            state_d = S_CHECK;
          end else begin
            cnt_d   = cnt_q + FW'(1);
            state_d = S_RD;
          end
        end
      end

      S_ENDM: begin
        if (push_ok) begin
          push  = 1'b1;
          out_d = '{out_byte: pnc_pkg::mark_byte(1'b1, mcnt_q),
                    chunk_end: (mcnt_q == pnc_pkg::MARK_LAST),
                    rejected: 1'b0,
                    run_last: (mcnt_q == pnc_pkg::MARK_LAST)};
          if (mcnt_q == pnc_pkg::MARK_LAST) begin
            clear_paste = 1'b1;
            state_d     = S_IDLE;
          end else begin
            mcnt_d = mcnt_q + pnc_pkg::MARK_W'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // End of paste resets the paste state.
    if (clear_paste) begin
      fill_d       = '0;
      pending_cr_d = 1'b0;
      dropping_d   = 1'b0;
      sent_d       = 1'b0;
    end
  end

  // The output register refills only when empty or being taken.
  always_comb begin
    if (push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      head_q       <= '0;
      pending_cr_q <= 1'b0;
      dropping_q   <= 1'b0;
      sent_q       <= 1'b0;
      have_q       <= 1'b0;
      last_q       <= 1'b0;
      cnt_q        <= '0;
      len_q        <= '0;
      mcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      head_q       <= head_d;
      pending_cr_q <= pending_cr_d;
      dropping_q   <= dropping_d;
      sent_q       <= sent_d;
      have_q       <= have_d;
      last_q       <= last_d;
      cnt_q        <= cnt_d;
      len_q        <= len_d;
      mcnt_q       <= mcnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    cont_q <= cont_d;
    if (push) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The ring never holds more than one chunk plus one byte.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(DEPTH))
    else $error("chunk store overfilled");

  // A byte is only appended while there is room for it.
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (fill_q < FW'(DEPTH)))
    else $error("write into a full chunk store");

  // A read stays inside the burst and inside the held bytes.
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (len_q != '0 && len_q <= fill_q && cnt_q < len_q))
    else $error("chunk read out of range");

  // A reject is only sent for a paste marked as dropped.
  a_reject_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REJ) |-> dropping_q)
    else $error("reject without a dropped paste");

endmodule

FILE: sim/pnc_chunk_checker.sv
`timescale 1ns / 1ps
// Checker for the paste normalizer and chunker: watches the in, out and cfg channels,
// predicts every result byte and compares it with each out transfer.
// Depends on pnc_pkg for the payload and config types and the character codes.
module pnc_chunk_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  pnc_pkg::pnc_in_t               in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  pnc_pkg::pnc_out_t              out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [pnc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             pending_o,
  output int                             errors_o
);

  // Bracket marker sequences, first byte in the top bits.
  localparam logic [47:0] OPEN_MARK  = 48'h1B5B3230307E;
  localparam logic [47:0] CLOSE_MARK = 48'h1B5B3230317E;

  // Shadow of the config registers and of the paste state.
  pnc_pkg::pnc_cfg_t          settings;
  logic [pnc_pkg::BYTE_W-1:0] held [pnc_pkg::STORE_DEPTH];
  int                         held_cnt;
  bit                         after_cr;
  bit                         rejecting;
  bit                         opened;

  // Result bytes still owed by the block, oldest first.
  pnc_pkg::pnc_out_t          due_q[$];
  pnc_pkg::pnc_out_t          want;
  int                         errors;

  function automatic bit utf_tail(input logic [pnc_pkg::BYTE_W-1:0] b);
    return (b & pnc_pkg::UTF_CONT_MASK) == pnc_pkg::UTF_CONT_TAG;
  endfunction

  task automatic clear_paste();
    held_cnt  = 0;
    after_cr  = 1'b0;
    rejecting = 1'b0;
    opened    = 1'b0;
  endtask

  task automatic expect_byte(input logic [pnc_pkg::BYTE_W-1:0] b, input bit closes_chunk,
                             input bit reject);
    pnc_pkg::pnc_out_t r;
    r.out_byte  = b;
    r.chunk_end = closes_chunk;
    r.rejected  = reject;
    r.run_last  = 1'b0;
    due_q = {due_q, r};
  endtask

  task automatic expect_marker(input bit closing);
    logic [47:0] seq;
    seq = closing ? CLOSE_MARK : OPEN_MARK;
    for (int i = 0; i < 6; i++) expect_byte(seq[47 - 8 * i -: 8], i == 5, 1'b0);
  endtask

  // Send the first n held bytes as one chunk and slide the rest down.
  task automatic release_head(input int n);
    int k;
    k = 0;
    for (int i = 0; i < n; i++) expect_byte(held[i], i == n - 1, 1'b0);
    for (int i = n; i < held_cnt; i++) begin
      held[k] = held[i];
      k++;
    end
    held_cnt = k;
  endtask

  // Store a surviving byte; cut while more than one chunk is held, never before a
  // UTF-8 continuation byte, but always keeping at least one byte in the cut.
  task automatic keep_byte(input logic [pnc_pkg::BYTE_W-1:0] b);
    int limit;
    int cut;
    limit = (settings.chunk_size == '0 ||
             settings.chunk_size > pnc_pkg::CHUNK_SIZE_W'(pnc_pkg::CHUNK_MAX))
            ? pnc_pkg::CHUNK_MAX : int'(settings.chunk_size);
    if (settings.bracketed_mode && !opened) begin
      expect_marker(1'b0);
      opened = 1'b1;
    end
    held[held_cnt] = b;
    held_cnt++;
    while (held_cnt > limit) begin
      cut = limit;
      while (cut > 1 && utf_tail(held[cut])) cut--;
      release_head(cut);
    end
  endtask

  // Work out every result caused by one accepted paste byte.
  task automatic predict_item(input pnc_pkg::pnc_in_t it);
    int                base;
    bit                was_cr;
    pnc_pkg::pnc_out_t tail;
    base = due_q.size();
    if (it.first_byte) begin
      clear_paste();
      if (it.total_length > settings.max_length) begin
        rejecting = 1'b1;
        expect_byte(8'h00, 1'b0, 1'b1);
      end
    end
    if (!rejecting) begin
      was_cr   = after_cr;
      after_cr = 1'b0;
      if (it.in_byte == pnc_pkg::CH_CR) begin
        keep_byte(pnc_pkg::CH_CR);
        after_cr = 1'b1;
      end else if (it.in_byte == pnc_pkg::CH_LF) begin
        // An LF right after a CR folds into it; a lone LF becomes CR.
        if (!was_cr) keep_byte(pnc_pkg::CH_CR);
      end else if (it.in_byte == pnc_pkg::CH_TAB) begin
        keep_byte(pnc_pkg::CH_TAB);
      end else if (it.in_byte < pnc_pkg::CH_SPACE || it.in_byte == pnc_pkg::CH_DEL) begin
        if (settings.bracketed_mode || !settings.strip_controls) keep_byte(it.in_byte);
      end else begin
        keep_byte(it.in_byte);
      end
      if (it.last_byte) begin
        if (held_cnt > 0) release_head(held_cnt);
        if (opened) expect_marker(1'b1);
      end
    end
    if (it.last_byte) clear_paste();
    if (due_q.size() > base) begin
      tail = due_q.pop_back();
      tail.run_last = 1'b1;
      due_q = {due_q, tail};
    end
  endtask

  // Out transfers are checked before a new in transfer adds to the queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings.bracketed_mode = 1'b1;
      settings.strip_controls = 1'b1;
      settings.max_length     = '1;
      settings.chunk_size     = '0;
      due_q.delete();
      clear_paste();
      errors = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got byte %02h end %0d big %0d last %0d",
                   $time, out_data_i.out_byte, out_data_i.chunk_end, out_data_i.rejected,
                   out_data_i.run_last);
        end else begin
          want = due_q.pop_front();
          if (out_data_i !== want) begin
            errors++;
            $display("%0t: mismatch: expected byte %02h end %0d big %0d last %0d, got %s",
                     $time, want.out_byte, want.chunk_end, want.rejected, want.run_last,
                     $sformatf("byte %02h end %0d big %0d last %0d", out_data_i.out_byte,
                               out_data_i.chunk_end, out_data_i.rejected,
                               out_data_i.run_last));
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pnc_pkg::CFG_BRACKETED:  settings.bracketed_mode = cfg_data_i[0];
          pnc_pkg::CFG_STRIP:      settings.strip_controls = cfg_data_i[0];
          pnc_pkg::CFG_MAX_LENGTH: settings.max_length     = cfg_data_i[pnc_pkg::LEN_W-1:0];
          pnc_pkg::CFG_CHUNK_SIZE:
            settings.chunk_size = cfg_data_i[pnc_pkg::CHUNK_SIZE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) predict_item(in_data_i);

      pending_o <= due_q.size();
      errors_o  <= errors;
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the paste normalizer and chunker: clock, reset, paste stimulus,
// config phases and random stalls on both sides; the checker supplies the error count.
// Depends on pnc_pkg, paste_normalize_chunker and pnc_chunk_checker.
module tb;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  pnc_pkg::pnc_in_t               in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  pnc_pkg::pnc_out_t              out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pnc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pnc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int pending;
  int mismatches;
  int cycle_cnt;
  int bytes_sent = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  paste_normalize_chunker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pnc_chunk_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or never drains.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 9);
      end
    end
  end

  function automatic pnc_pkg::pnc_in_t raw(input logic [pnc_pkg::BYTE_W-1:0] b,
                                           input bit first, input bit last,
                                           input logic [pnc_pkg::LEN_W-1:0] total);
    pnc_pkg::pnc_in_t it;
    it.in_byte      = b;
    it.first_byte   = first;
    it.last_byte    = last;
    it.total_length = total;
    return it;
  endfunction

  // One in transfer; valid stays high afterwards unless the next call idles first.
  task automatic send_item(input pnc_pkg::pnc_in_t item);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Stop sending and wait until every owed result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [pnc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [pnc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers back to back; only called while the block is idle.
  task automatic load_settings(input bit brk, input bit strip,
                               input logic [pnc_pkg::LEN_W-1:0] cap,
                               input logic [pnc_pkg::CHUNK_SIZE_W-1:0] csize);
    put_reg(pnc_pkg::CFG_BRACKETED, pnc_pkg::CFG_DATA_W'(brk));
    put_reg(pnc_pkg::CFG_STRIP, pnc_pkg::CFG_DATA_W'(strip));
    put_reg(pnc_pkg::CFG_MAX_LENGTH, pnc_pkg::CFG_DATA_W'(cap));
    put_reg(pnc_pkg::CFG_CHUNK_SIZE, pnc_pkg::CFG_DATA_W'(csize));
    cfg_valid <= 1'b0;
  endtask

  // A random paste: mostly well formed, with UTF-8 runs, line endings and controls;
  // a few lack the opening or closing flag, and a few carry stray flags.
  task automatic send_paste(input int len);
    pnc_pkg::pnc_in_t              item;
    logic [pnc_pkg::LEN_W-1:0]     claim;
    bit                            headless;
    bit                            open_ended;
    int                            tail_left;
    int                            pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) claim = pnc_pkg::LEN_W'(len);
    else if (pick < 80) claim = pnc_pkg::LEN_W'($urandom_range(0, 64));
    else claim = pnc_pkg::LEN_W'($urandom);
    headless   = $urandom_range(0, 99) < 5;
    open_ended = $urandom_range(0, 99) < 8;
    tail_left  = 0;
    for (int i = 0; i < len; i++) begin
      if (tail_left > 0) begin
        item.in_byte = pnc_pkg::BYTE_W'($urandom_range(8'h80, 8'hBF));
        tail_left--;
      end else begin
        case ($urandom_range(0, 9))
          0:       item.in_byte = pnc_pkg::CH_CR;
          1:       item.in_byte = pnc_pkg::CH_LF;
          2:       item.in_byte = pnc_pkg::CH_TAB;
          3:       item.in_byte = pnc_pkg::BYTE_W'($urandom_range(0, 31));
          4:       item.in_byte = pnc_pkg::CH_DEL;
          5, 6:    item.in_byte = pnc_pkg::BYTE_W'($urandom_range(32, 126));
          7: begin
            item.in_byte = pnc_pkg::BYTE_W'($urandom_range(8'hC0, 8'hFF));
            tail_left    = $urandom_range(1, 3);
          end
          8:       item.in_byte = pnc_pkg::BYTE_W'($urandom_range(8'h80, 8'hBF));
          default: item.in_byte = pnc_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
      end
      item.first_byte   = (i == 0) && !headless;
      item.last_byte    = (i == len - 1) && !open_ended;
      item.total_length = (i == 0) ? claim : pnc_pkg::LEN_W'($urandom);
      if ($urandom_range(0, 99) < 3) begin
        item.first_byte = 1'($urandom_range(0, 1));
        item.last_byte  = 1'($urandom_range(0, 1));
      end
      send_item(item);
    end
  endtask

  initial begin : stimulus
    int                        phase;
    int                        target;
    logic [pnc_pkg::LEN_W-1:0] cap;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: bracketed, chunk length at its maximum.
    send_item(raw(8'h41, 1'b1, 1'b1, 24'hFFFFFF));
    send_item(raw(8'h41, 1'b1, 1'b0, 24'd0));
    send_item(raw(pnc_pkg::CH_CR, 1'b0, 1'b0, 24'd7));
    send_item(raw(pnc_pkg::CH_LF, 1'b0, 1'b0, 24'd0));
    send_item(raw(pnc_pkg::CH_LF, 1'b0, 1'b0, 24'hFFFFFF));
    send_item(raw(pnc_pkg::CH_TAB, 1'b0, 1'b0, 24'h123456));
    send_item(raw(8'h00, 1'b0, 1'b0, 24'h0));
    send_item(raw(pnc_pkg::CH_DEL, 1'b0, 1'b0, 24'h0));
    send_item(raw(8'hFF, 1'b0, 1'b0, 24'h0));
    send_item(raw(pnc_pkg::CH_SPACE, 1'b0, 1'b1, 24'hABCDEF));

    // Unbracketed with stripping: an oversized paste, an all-control paste that
    // leaves nothing, and a UTF-8 character that must not be split by a cut.
    settle();
    load_settings(1'b0, 1'b1, 24'd5, 5'd3);
    send_item(raw(8'h61, 1'b1, 1'b0, 24'd6));
    send_item(raw(8'h62, 1'b0, 1'b0, 24'd0));
    send_item(raw(8'h63, 1'b0, 1'b1, 24'd0));
    send_item(raw(8'h01, 1'b1, 1'b0, 24'd5));
    send_item(raw(8'h1B, 1'b0, 1'b1, 24'd0));
    send_item(raw(8'h61, 1'b1, 1'b0, 24'd5));
    send_item(raw(8'hE2, 1'b0, 1'b0, 24'd0));
    send_item(raw(8'h82, 1'b0, 1'b0, 24'd0));
    send_item(raw(8'hAC, 1'b0, 1'b0, 24'd0));
    send_item(raw(8'h62, 1'b0, 1'b1, 24'd0));

    // Mode and chunk length change in the middle of an open paste.
    settle();
    load_settings(1'b0, 1'b0, 24'hFFFFFF, 5'd16);
    send_item(raw(8'h70, 1'b1, 1'b0, 24'd7));
    send_item(raw(8'h01, 1'b0, 1'b0, 24'd0));
    send_item(raw(8'h71, 1'b0, 1'b0, 24'd0));
    send_item(raw(8'h73, 1'b0, 1'b0, 24'd0));
    send_item(raw(8'h74, 1'b0, 1'b0, 24'd0));
    settle();
    load_settings(1'b1, 1'b0, 24'hFFFFFF, 5'd2);
    send_item(raw(8'h72, 1'b0, 1'b1, 24'd0));

    // Random pastes under a series of settings.
    for (phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: load_settings(1'b1, 1'b1, 24'hFFFFFF, 5'd16);
        1: load_settings(1'b0, 1'b1, pnc_pkg::LEN_W'($urandom_range(8, 40)), 5'd1);
        2: load_settings(1'b0, 1'b0, 24'hFFFFFF, 5'd31);
        3: load_settings(1'b1, 1'b0, 24'd0, 5'd0);
        default: begin
          case ($urandom_range(0, 2))
            0:       cap = pnc_pkg::LEN_W'($urandom_range(0, 48));
            1:       cap = pnc_pkg::LEN_W'($urandom);
            default: cap = 24'hFFFFFF;
          endcase
          load_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cap,
                        pnc_pkg::CHUNK_SIZE_W'($urandom_range(0, 31)));
        end
      endcase
      calm = (phase == 4);
      // The long output hold-off lands while the sender keeps offering bytes.
      if (phase == 0) hold_request = 1'b1;
      target = bytes_sent + ((phase == 3) ? 20 : 50);
      while (bytes_sent < target)
        send_paste(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                : $urandom_range(1, 20));
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pnc_pkg.sv
rtl/pnc_cfg.sv
rtl/pnc_store.sv
rtl/pnc_ctrl.sv
rtl/paste_normalize_chunker.sv
sim/pnc_chunk_checker.sv
sim/tb.sv
